// File: rtl/assert_macros.svh
// Assertion macros for the RTL file that carries checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define QST_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define QST_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/qst_pkg.sv
// Package for the quintic segment trajectory block: widths, constants,
// sequencer state type and the sequencer control struct. No dependencies.
package qst_pkg;

   // Field widths
   localparam int POS_BITS   = 16;
   localparam int TIME_BITS  = 16;
   localparam int TICKS_BITS = 16;

   // Q0.16 fraction: S and its powers run from 0 to 1.0 inclusive
   localparam int FRAC_BITS = 16;
   localparam int S_BITS    = FRAC_BITS + 1;
   localparam logic [S_BITS-1:0] FRAC_ONE = S_BITS'(1) << FRAC_BITS;
   localparam logic [TICKS_BITS-1:0] TICKS_RESET = TICKS_BITS'(1000);

   // Shared multiplier operand widths
   localparam int MUL_A_BITS = S_BITS + 1;
   localparam int MUL_B_BITS = (POS_BITS + 1 > MUL_A_BITS) ? POS_BITS + 1 : MUL_A_BITS;
   localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

   // Divider remainder compare width
   localparam int CMP_BITS     = ((TIME_BITS > TICKS_BITS) ? TIME_BITS : TICKS_BITS) + 1;
   localparam int DIV_CNT_BITS = $clog2(FRAC_BITS);

   // Weight accumulator: holds 1 - 10p3 + 15p4 - 6p5 before clamping
   localparam int ACC_BITS = S_BITS + 6;

   // Power index codes
   localparam int POW_BITS = 3;
   localparam logic [POW_BITS-1:0] POW_SQ     = POW_BITS'(2);
   localparam logic [POW_BITS-1:0] POW_CUBE   = POW_BITS'(3);
   localparam logic [POW_BITS-1:0] POW_FOURTH = POW_BITS'(4);
   localparam logic [POW_BITS-1:0] POW_FIFTH  = POW_BITS'(5);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL,
      ST_ACC,
      ST_WMUL,
      ST_FIN
   } state_type;

   // Sequencer outputs
   typedef struct packed {
      logic req_ready;
      logic div_start;
      logic mul_en;
      logic mul_wsel;
      logic load_rsp;
   } ctl_type;

endpackage

// File: rtl/qst_channels.sv
// Channel interfaces for the trajectory block: request, response, CSR write.
// Depends on qst_pkg for field widths.
interface qst_req_if import qst_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic signed [POS_BITS-1:0] waypoint;

   modport source (output valid, opcode, waypoint, input ready);
   modport sink   (input valid, opcode, waypoint, output ready);
endinterface

interface qst_rsp_if import qst_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [POS_BITS-1:0] position;
   logic                       segment_done;

   modport source (output valid, position, segment_done, input ready);
   modport sink   (input valid, position, segment_done, output ready);
endinterface

interface qst_csr_if import qst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TICKS_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: rtl/qst_div.sv
// Iterative restoring divider: floor(dividend * 2^FRAC_BITS / divisor),
// one quotient bit per cycle. Requires dividend < divisor. Depends on qst_pkg.
module qst_div import qst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_BITS-1:0]  dividend,
   input  logic [TICKS_BITS-1:0] divisor,
   output logic                  busy,
   output logic                  done,
   output logic [FRAC_BITS-1:0]  quotient
);

   logic [CMP_BITS-1:0]     rem_ff, rem_in, rem_sh, div_x;
   logic [TICKS_BITS-1:0]   div_ff;
   logic [FRAC_BITS-1:0]    quo_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic                    busy_ff, done_ff;
   logic                    ge;

   // One restoring step
   always_comb begin
      rem_sh = rem_ff << 1;
      div_x  = {{(CMP_BITS-TICKS_BITS){1'b0}}, div_ff};
      ge     = (rem_sh >= div_x);
      rem_in = ge ? (rem_sh - div_x) : rem_sh;
   end

   // Control: busy through FRAC_BITS restoring steps, then a one-cycle done pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + DIV_CNT_BITS'(1);
            if (cnt_ff == DIV_CNT_BITS'(FRAC_BITS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and quotient shift
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {{(CMP_BITS-TIME_BITS){1'b0}}, dividend};
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[FRAC_BITS-2:0], ge};
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/qst_mul.sv
// Shared signed multiplier with a registered product.
// Depends on qst_pkg for operand widths.
module qst_mul import qst_pkg::*; (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [MUL_A_BITS-1:0] a,
   input  logic signed [MUL_B_BITS-1:0] b,
   output logic signed [PROD_BITS-1:0]  product
);

   logic signed [PROD_BITS-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= PROD_BITS'(a) * PROD_BITS'(b);
      end
   end

   assign product = prod_ff;

endmodule

// File: rtl/quintic_segment_trajectory_top.sv
// Top level of the minimum-jerk quintic segment trajectory generator.
// Depends on qst_pkg, the channel interfaces, qst_div, qst_mul, assert_macros.svh.
//
// Usage:
//   req: one request per transfer. opcode 1 pushes a waypoint: the old end
//        point becomes the start point, the waypoint becomes the end point and
//        the tick counter clears; no response. opcode 0 is a sample tick.
//   rsp: one response per tick: position (Q4.12) and segment_done.
//   csr: writes segment_ticks (samples per segment, 0 acts as 1); always ready.
//        Write only while no tick is in flight.
// Sequence and throughput:
//   A waypoint updates the segment registers when accepted. A tick runs from
//   acceptance to rsp valid through the bit-serial divider forming s (load plus
//   16 steps), the four power steps on the shared multiplier, the weight product
//   and the output register. Once the counter reaches segment_ticks the divider
//   is skipped. The request side is ready only while the sequencer is idle, so a
//   new tick is accepted only once the previous one has reached the output register.
// Reset: segment_ticks = 1000, start, end and tick counter cleared.
// Stall: a finished sample waits in the output register; the sequencer
//   accepts new requests meanwhile and holds the next sample until rsp frees.
`include "assert_macros.svh"

module quintic_segment_trajectory_top import qst_pkg::*; (
   input logic      clock,
   input logic      reset,
   qst_req_if.sink   req,
   qst_rsp_if.source rsp,
   qst_csr_if.sink   csr
);

   state_type state_ff, state_in;
   ctl_type   ctl;

   logic [TICKS_BITS-1:0]      ticks_ff;
   logic signed [POS_BITS-1:0] seg_start_ff, seg_end_ff;
   logic [TIME_BITS-1:0]       tick_ff;

   logic [S_BITS-1:0]          s_ff, p_ff, p_in, w_val;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in, pe;
   logic [POW_BITS-1:0]        pow_ff;

   logic                       rsp_valid_ff, rsp_done_ff;
   logic signed [POS_BITS-1:0] rsp_pos_ff;

   logic [TICKS_BITS-1:0]      ticks_eff;
   logic [CMP_BITS-1:0]        tick_x, ticks_x;
   logic                       saturated, last_sample, req_acc;

   logic                         div_busy, div_done;
   logic [FRAC_BITS-1:0]         div_q;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod, rounded;
   logic signed [POS_BITS:0]     diff;
   logic signed [POS_BITS+1:0]   delta, pos_x;
   logic signed [POS_BITS-1:0]   pos_sat;

   // Segment timing
   always_comb begin
      ticks_eff   = (ticks_ff == '0) ? TICKS_BITS'(1) : ticks_ff;
      tick_x      = {{(CMP_BITS-TIME_BITS){1'b0}}, tick_ff};
      ticks_x     = {{(CMP_BITS-TICKS_BITS){1'b0}}, ticks_eff};
      saturated   = (tick_x >= ticks_x);
      last_sample = ((tick_x + CMP_BITS'(1)) >= ticks_x);
      req_acc     = req.valid && ctl.req_ready;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && !req.opcode) begin
               state_in = saturated ? ST_MUL : ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_ACC;
         ST_ACC:  state_in = (pow_ff == POW_FIFTH) ? ST_WMUL : ST_MUL;
         ST_WMUL: state_in = ST_FIN;
         ST_FIN: begin
            if (ctl.load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctl           = '0;
      ctl.req_ready = (state_ff == ST_IDLE);
      ctl.div_start = (state_ff == ST_IDLE) && req.valid && !req.opcode && !saturated;
      ctl.mul_en    = (state_ff == ST_MUL) || (state_ff == ST_WMUL);
      ctl.mul_wsel  = (state_ff == ST_WMUL);
      ctl.load_rsp  = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TICKS_RESET;
      end else if (csr.valid && csr.ready) begin
         ticks_ff <= csr.data;
      end
   end

   assign csr.ready = 1'b1;

   // Segment state: waypoint shift and tick counter advance
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_start_ff <= '0;
         seg_end_ff   <= '0;
         tick_ff      <= '0;
      end else if (req_acc && req.opcode) begin
         seg_start_ff <= seg_end_ff;
         seg_end_ff   <= req.waypoint;
         tick_ff      <= '0;
      end else if (ctl.load_rsp && (tick_ff != '1)) begin
         tick_ff <= tick_ff + TIME_BITS'(1);
      end
   end

   qst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctl.div_start),
      .dividend (tick_ff),
      .divisor  (ticks_eff),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   // Weight clamp to [0, 1.0]
   always_comb begin
      if (acc_ff[ACC_BITS-1]) begin
         w_val = '0;
      end else if (acc_ff > ACC_BITS'(FRAC_ONE)) begin
         w_val = FRAC_ONE;
      end else begin
         w_val = acc_ff[S_BITS-1:0];
      end
   end

   // Shared multiplier operands: power step or weight times span
   always_comb begin
      diff = (POS_BITS+1)'(seg_end_ff) - (POS_BITS+1)'(seg_start_ff);
      if (ctl.mul_wsel) begin
         mul_a = {1'b0, w_val};
         mul_b = MUL_B_BITS'(diff);
      end else begin
         mul_a = {1'b0, p_ff};
         mul_b = {{(MUL_B_BITS-S_BITS){1'b0}}, s_ff};
      end
   end

   qst_mul u_mul (
      .clock   (clock),
      .enable  (ctl.mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod)
   );

   // Round to Q0.16 and fold the new power into the weight
   always_comb begin
      rounded = prod + PROD_BITS'(32768);
      p_in    = rounded[FRAC_BITS +: S_BITS];
      pe      = ACC_BITS'({1'b0, p_in});
      unique case (pow_ff)
         POW_CUBE:   acc_in = acc_ff - ((pe <<< 3) + (pe <<< 1));
         POW_FOURTH: acc_in = acc_ff + ((pe <<< 4) - pe);
         POW_FIFTH:  acc_in = acc_ff - ((pe <<< 2) + (pe <<< 1));
         default:    acc_in = acc_ff;
      endcase
   end

   // Power chain registers
   always_ff @(posedge clock) begin
      if (req_acc && !req.opcode) begin
         s_ff   <= FRAC_ONE;
         p_ff   <= FRAC_ONE;
         acc_ff <= ACC_BITS'(FRAC_ONE);
         pow_ff <= POW_SQ;
      end else if (state_ff == ST_DIV && div_done) begin
         s_ff <= {1'b0, div_q};
         p_ff <= {1'b0, div_q};
      end else if (state_ff == ST_ACC) begin
         p_ff   <= p_in;
         acc_ff <= acc_in;
         pow_ff <= pow_ff + POW_BITS'(1);
      end
   end

   // Position = end - delta, saturated to the field range
   always_comb begin
      delta = rounded[FRAC_BITS +: POS_BITS+2];
      pos_x = (POS_BITS+2)'(seg_end_ff) - delta;
      if (pos_x[POS_BITS+1] != pos_x[POS_BITS] || pos_x[POS_BITS] != pos_x[POS_BITS-1]) begin
         pos_sat = {pos_x[POS_BITS+1], {(POS_BITS-1){~pos_x[POS_BITS+1]}}};
      end else begin
         pos_sat = pos_x[POS_BITS-1:0];
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_rsp) begin
         rsp_pos_ff  <= pos_sat;
         rsp_done_ff <= last_sample;
      end
   end

   assign req.ready        = ctl.req_ready;
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.position     = rsp_pos_ff;
   assign rsp.segment_done = rsp_done_ff;

   // Checks
   `QST_ASSERT(a_wp_clears_tick, clock, reset, (req.valid && req.ready && req.opcode) |=> (tick_ff == '0), "waypoint did not clear tick counter")
   `QST_ASSERT(a_tick_starts_work, clock, reset, (req.valid && req.ready && !req.opcode) |=> (state_ff != ST_IDLE), "tick request did not start the sequencer")
   `QST_ASSERT(a_div_only_in_div, clock, reset, div_busy |-> (state_ff == ST_DIV), "divider busy outside the divide state")
   `QST_NEVER(a_no_overwrite, clock, reset, (state_ff == ST_FIN) && rsp_valid_ff && !rsp.ready && ctl.load_rsp, "pending response overwritten")

endmodule
